// ----- src/dcfs_pkg.sv -----
// Shared types and constants for the drive command CAN frame scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dcfs_pkg;

	// Item kind carried in the input tuser bit
	typedef enum logic {
		OP_CMD  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// Stored gear selection
	typedef enum logic [1:0] {
		SHIFT_FWD = 2'd0,
		SHIFT_REV = 2'd1,
		SHIFT_NEU = 2'd2
	} shift_t;

	localparam logic [10:0] ID_GEAR  = 11'h301;
	localparam logic [10:0] ID_BRAKE = 11'h131;
	localparam logic [10:0] ID_STEER = 11'h703;

	localparam logic [3:0] SLOT_LAST = 4'd9;

	// Decoded command fields
	typedef struct packed {
		logic [15:0] steer;
		logic [15:0] throttle;
		logic [15:0] brake;
		logic [7:0]  gear;
	} cmd_t;

	// Stored drive values
	typedef struct packed {
		logic [7:0] wheel_hi;
		logic [7:0] wheel_lo;
		logic [1:0] speed_hi;
		logic [7:0] speed_lo;
		shift_t     shift_code;
		logic [3:0] brake_level;
	} drive_t;

	// One CAN frame plus end-of-tick mark; data[0] is byte 0
	typedef struct packed {
		logic [10:0]     id;
		logic [7:0][7:0] data;
		logic            last;
	} frame_t;

endpackage

`default_nettype wire

// ----- src/dcfs_drive.sv -----
// Drive value registers: converts a command beat into steering, speed,
// gear and brake values. Depends on dcfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcfs_drive
	import dcfs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cmd_go,
	input  wire cmd_t   cmd,
	output drive_t      drive
);

	// 2^26 / 1600 rounded up; exact quotient for offsets up to 32768
	localparam logic [15:0] STEER_RECIP = 16'd41944;
	localparam logic [7:0]  WHEEL_BIAS  = 8'd29;
	localparam logic [15:0] SPEED_STEP1 = 16'd18000;
	localparam logic [15:0] SPEED_STEP2 = 16'd36000;
	localparam logic [15:0] SPEED_STEP3 = 16'd54000;
	localparam int          BRAKE_DIV   = 30;
	localparam int          BRAKE_STEPS = 8;

	logic [15:0] steer_mag;
	logic [31:0] steer_prod;
	logic [5:0]  steer_q;
	logic [15:0] thr_inv;
	logic [7:0]  brk_inv;
	drive_t      drive_next;
	drive_t      drive_q;

	always_comb begin
		// |steer - 32768|
		if (cmd.steer[15]) begin
			steer_mag = {1'b0, cmd.steer[14:0]};
		end else begin
			steer_mag = 16'h8000 - cmd.steer;
		end
		steer_prod = 32'(steer_mag) * 32'(STEER_RECIP);
		steer_q    = steer_prod[31:26];

		thr_inv = ~cmd.throttle;
		brk_inv = ~cmd.brake[15:8];

		drive_next.wheel_lo = cmd.steer[7:0];
		if (cmd.steer[15]) begin
			drive_next.wheel_hi = WHEEL_BIAS + {2'b00, steer_q};
		end else begin
			drive_next.wheel_hi = WHEEL_BIAS - {2'b00, steer_q};
		end

		priority if (thr_inv >= SPEED_STEP3) begin
			drive_next.speed_hi = 2'd3;
		end else if (thr_inv >= SPEED_STEP2) begin
			drive_next.speed_hi = 2'd2;
		end else if (thr_inv >= SPEED_STEP1) begin
			drive_next.speed_hi = 2'd1;
		end else begin
			drive_next.speed_hi = 2'd0;
		end
		drive_next.speed_lo = thr_inv[7:0];

		// quotient by 30 as a count of thresholds passed
		drive_next.brake_level = 4'd0;
		for (int k = 1; k <= BRAKE_STEPS; k++) begin
			if (brk_inv >= 8'(BRAKE_DIV * k)) begin
				drive_next.brake_level = drive_next.brake_level + 4'd1;
			end
		end

		priority if (cmd.gear == 8'd2) begin
			drive_next.shift_code = SHIFT_FWD;
		end else if (cmd.gear == 8'd0) begin
			drive_next.shift_code = SHIFT_REV;
		end else begin
			drive_next.shift_code = SHIFT_NEU;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q.wheel_hi    <= 8'd28;
			drive_q.wheel_lo    <= 8'd232;
			drive_q.speed_hi    <= 2'd0;
			drive_q.speed_lo    <= 8'd0;
			drive_q.shift_code  <= SHIFT_FWD;
			drive_q.brake_level <= 4'd0;
		end else if (cmd_go) begin
			drive_q <= drive_next;
		end
	end

	assign drive = drive_q;

endmodule

`default_nettype wire

// ----- src/dcfs_sched.sv -----
// Slot schedule and frame builder: picks the next frame of the current
// tick and assembles its bytes. Depends on dcfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcfs_sched
	import dcfs_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   tick_go,
	input  wire drive_t drive,
	output frame_t      frame
);

	typedef enum logic [1:0] {
		FR_GEAR  = 2'd0,
		FR_BRAKE = 2'd1,
		FR_STEER = 2'd2
	} frame_sel_t;

	logic [3:0] slot_q;
	logic [3:0] gear_count_q;
	logic [3:0] brake_count_q;
	logic       gear_done_q;
	logic       brake_done_q;

	logic       gear_slot;
	logic       brake_slot;
	logic       braking;
	frame_sel_t sel;
	logic [7:0] gear_b0;

	assign gear_slot  = (slot_q == 4'd0) || (slot_q == 4'd5);
	assign brake_slot = slot_q[0] && (slot_q <= SLOT_LAST);
	assign braking    = drive.brake_level != 4'd0;

	always_comb begin
		priority if (gear_slot && !gear_done_q) begin
			sel = FR_GEAR;
		end else if (brake_slot && !brake_done_q) begin
			sel = FR_BRAKE;
		end else begin
			sel = FR_STEER;
		end
	end

	always_comb begin
		if (braking) begin
			gear_b0 = 8'h80;
		end else begin
			unique case (drive.shift_code)
				SHIFT_FWD: gear_b0 = 8'hA0;
				SHIFT_REV: gear_b0 = 8'hC0;
				default:   gear_b0 = 8'h80;
			endcase
		end
	end

	always_comb begin
		frame.data = '0;
		frame.last = 1'b0;
		unique case (sel)
			FR_GEAR: begin
				frame.id      = ID_GEAR;
				frame.data[0] = gear_b0;
				frame.data[1] = braking ? 8'h00 : {6'b0, drive.speed_hi};
				frame.data[2] = braking ? 8'h00 : drive.speed_lo;
				frame.data[3] = 8'h04;
				frame.data[4] = 8'h20;
				frame.data[5] = {gear_count_q, 4'h0};
				frame.data[6] = frame.data[0] + frame.data[1] + frame.data[2]
					+ frame.data[3] + frame.data[4] + frame.data[5];
			end
			FR_BRAKE: begin
				frame.id      = ID_BRAKE;
				frame.data[0] = braking ? 8'h40 : 8'h42;
				// level is zero whenever not braking
				frame.data[2] = {4'h0, drive.brake_level};
				frame.data[6] = {4'h0, brake_count_q};
				frame.data[7] = frame.data[0] + frame.data[2] + frame.data[6];
			end
			default: begin
				frame.id      = ID_STEER;
				frame.data[0] = 8'h01;
				frame.data[1] = drive.wheel_hi;
				frame.data[2] = drive.wheel_lo;
				frame.data[3] = 8'h20;
				frame.data[7] = frame.data[0] + frame.data[1] + frame.data[2]
					+ frame.data[3];
				frame.last    = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q        <= 4'd0;
			gear_count_q  <= 4'd0;
			brake_count_q <= 4'd0;
			gear_done_q   <= 1'b0;
			brake_done_q  <= 1'b0;
		end else if (tick_go) begin
			unique case (sel)
				FR_GEAR: begin
					gear_done_q  <= 1'b1;
					gear_count_q <= gear_count_q + 4'd1;
				end
				FR_BRAKE: begin
					brake_done_q  <= 1'b1;
					brake_count_q <= brake_count_q + 4'd1;
				end
				default: begin
					gear_done_q  <= 1'b0;
					brake_done_q <= 1'b0;
					slot_q       <= (slot_q >= SLOT_LAST) ? 4'd0 : slot_q + 4'd1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/drive_command_can_frame_scheduler.sv -----
// Top level of the drive command CAN frame scheduler: input register,
// output register and handshakes. Depends on dcfs_pkg, dcfs_drive, dcfs_sched.
`timescale 1ns / 1ps
`default_nettype none

// Takes command and tick beats on the slave stream and plays out a 10-slot
// CAN schedule on the master stream. A command beat (tuser = 0) updates the
// stored steering, speed, gear and brake values and emits nothing. A tick
// beat (tuser = 1) emits the frames of the current slot in the order 0x301
// (slots 0 and 5), 0x131 (odd slots), 0x703 (every slot), one frame per
// cycle while the output register is free, with tlast on the 0x703 frame;
// then the slot advances. A tick holds the input register, one frame at a
// time into the single output register, until its last frame loads; the
// next beat is accepted in the cycle the last frame loads, so commands run
// at one per cycle. A full output register holds while m_tready is low; the
// input register can still take a beat behind it, where a tick then waits.
// Frame bytes come from the drive values current when each frame loads;
// 4-bit rolling counters step per 0x301 and 0x131 frame sent.

module drive_command_can_frame_scheduler
	import dcfs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// steer_cmd[15:0], throttle_cmd[31:16], brake_cmd[47:32], gear_cmd[55:48]
	input  wire logic [55:0] s_tdata,
	// op[0]
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// data0[7:0], data1[15:8], ... data7[63:56]
	output logic [63:0]      m_tdata,
	// frame_id[10:0]
	output logic [10:0]      m_tuser,
	output logic             m_tlast
);

	// input stage
	logic   valid_s1;
	op_t    op_s1;
	cmd_t   cmd_s1;

	// output stage
	logic   out_valid_q;
	frame_t out_q;

	logic   out_free;
	logic   tick_go;
	logic   cmd_go;
	logic   s1_done;
	drive_t drive;
	frame_t frame;

	assign out_free = !out_valid_q || m_tready;
	assign cmd_go   = valid_s1 && (op_s1 == OP_CMD);
	assign tick_go  = valid_s1 && (op_s1 == OP_TICK) && out_free;
	// a command retires at once; a tick when its last frame loads
	assign s1_done  = cmd_go || (tick_go && frame.last);
	assign s_tready = !valid_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1           <= op_t'(s_tuser[0]);
			cmd_s1.steer    <= s_tdata[15:0];
			cmd_s1.throttle <= s_tdata[31:16];
			cmd_s1.brake    <= s_tdata[47:32];
			cmd_s1.gear     <= s_tdata[55:48];
		end
	end

	dcfs_drive u_drive (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_go (cmd_go),
		.cmd    (cmd_s1),
		.drive  (drive)
	);

	dcfs_sched u_sched (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_go (tick_go),
		.drive   (drive),
		.frame   (frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= tick_go;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			out_q <= frame;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.data[7], out_q.data[6], out_q.data[5], out_q.data[4],
		out_q.data[3], out_q.data[2], out_q.data[1], out_q.data[0]};
	assign m_tuser  = out_q.id;
	assign m_tlast  = out_q.last;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for drive_command_can_frame_scheduler: stream driver, stream monitor
// and a built-in predictor of the CAN schedule. Depends on dcfs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
	import dcfs_pkg::*;

	// run control
	localparam int IDLE_LIMIT    = 3000;  // cycles with no beat on either side
	localparam int TAIL_CYCLES   = 8;
	localparam int RANDOM_BEATS  = 210;
	localparam int PAUSE_AT      = 150;   // random beat index where the sender drains
	localparam int HOLD_AT_FRAME = 100;   // frame count that starts the long receiver hold
	localparam int HOLD_CYCLES   = 120;

	// command decode
	localparam logic [7:0] GEAR_CMD_FWD = 8'd2;
	localparam logic [7:0] GEAR_CMD_REV = 8'd0;
	localparam int STEER_CENTER = 32768;
	localparam int STEER_STEP   = 1600;
	localparam int STEER_OFFSET = 29;
	localparam int THROTTLE_TOP = 65535;
	localparam int SPEED_STEP   = 18000;
	localparam int BRAKE_TOP    = 255;
	localparam int BRAKE_STEP   = 30;
	localparam logic [7:0] WHEEL_HI_RST = 8'd28;
	localparam logic [7:0] WHEEL_LO_RST = 8'd232;

	// schedule and payload constants
	localparam logic [3:0] GEAR_SLOT_A  = 4'd0;
	localparam logic [3:0] GEAR_SLOT_B  = 4'd5;
	localparam logic [7:0] MODE_FWD     = 8'hA0;
	localparam logic [7:0] MODE_REV     = 8'hC0;
	localparam logic [7:0] MODE_NEU     = 8'h80;  // also sent while braking
	localparam logic [7:0] GEAR_BYTE3   = 8'h04;
	localparam logic [7:0] BYTE_20      = 8'h20;
	localparam logic [7:0] BRAKE_ON     = 8'h40;
	localparam logic [7:0] BRAKE_OFF    = 8'h42;
	localparam logic [7:0] STEER_BYTE0  = 8'h01;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_HALF,
		READY_SPARSE
	} ready_mode_t;

	// one stimulus entry; pause marks a point where the sender waits for all frames
	typedef struct packed {
		logic        pause;
		op_t         op;
		logic [15:0] steer;
		logic [15:0] throttle;
		logic [15:0] brake;
		logic [7:0]  gear;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire logic   s_tready;
	logic [55:0] s_tdata = '0;   // steer[15:0], throttle[31:16], brake[47:32], gear[55:48]
	logic [0:0]  s_tuser = OP_CMD; // op[0]
	wire logic   m_tvalid;
	logic        m_tready = 1'b0;
	wire logic [63:0] m_tdata;   // data0[7:0], data1[15:8], ... data7[63:56]
	wire logic [10:0] m_tuser;   // frame_id[10:0]
	wire logic   m_tlast;

	drive_command_can_frame_scheduler DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Schedule predictor: its own copy of the drive values and counters.
	// ------------------------------------------------------------------
	logic [3:0] slot_q;
	logic [3:0] gear_roll;
	logic [3:0] brake_roll;
	logic [7:0] wheel_hi;
	logic [7:0] wheel_lo;
	logic [1:0] speed_hi;
	logic [7:0] speed_lo;
	shift_t     shift;
	logic [3:0] brake_level;

	frame_t owed_frames[$];   // frames predicted but not yet seen, oldest first

	function automatic logic [7:0] byte_sum(logic [7:0][7:0] d, int n);
		logic [7:0] s;
		s = 8'd0;
		for (int i = 0; i < n; i++)
			s += d[i];
		return s;
	endfunction

	// Applies one accepted beat, queues the frames it owes, returns how many.
	function automatic int play_beat(beat_t b);
		frame_t f;
		int q;
		int span;
		int made;
		logic braking;
		made = 0;
		if (b.op == OP_CMD) begin
			// signed division truncates toward zero, as the steering scale wants
			q = (int'(b.steer) - STEER_CENTER) / STEER_STEP;
			wheel_hi = 8'(q + STEER_OFFSET);
			wheel_lo = b.steer[7:0];
			span = THROTTLE_TOP - int'(b.throttle);
			speed_hi = 2'(span / SPEED_STEP);
			speed_lo = 8'(span);
			brake_level = 4'((BRAKE_TOP - int'(b.brake[15:8])) / BRAKE_STEP);
			if (b.gear == GEAR_CMD_FWD)
				shift = SHIFT_FWD;
			else if (b.gear == GEAR_CMD_REV)
				shift = SHIFT_REV;
			else
				shift = SHIFT_NEU;
			return 0;
		end
		braking = brake_level != 4'd0;
		// gear and speed frame
		if (slot_q == GEAR_SLOT_A || slot_q == GEAR_SLOT_B) begin
			f = '0;
			f.id = ID_GEAR;
			if (braking)
				f.data[0] = MODE_NEU;
			else if (shift == SHIFT_FWD)
				f.data[0] = MODE_FWD;
			else if (shift == SHIFT_REV)
				f.data[0] = MODE_REV;
			else
				f.data[0] = MODE_NEU;
			f.data[1] = braking ? 8'd0 : {6'd0, speed_hi};
			f.data[2] = braking ? 8'd0 : speed_lo;
			f.data[3] = GEAR_BYTE3;
			f.data[4] = BYTE_20;
			f.data[5] = {gear_roll, 4'd0};
			f.data[6] = byte_sum(f.data, 6);
			owed_frames.push_back(f);
			made++;
			gear_roll++;
		end
		// brake frame on odd slots
		if (slot_q[0]) begin
			f = '0;
			f.id = ID_BRAKE;
			f.data[0] = braking ? BRAKE_ON : BRAKE_OFF;
			f.data[2] = braking ? {4'd0, brake_level} : 8'd0;
			f.data[6] = {4'd0, brake_roll};
			f.data[7] = byte_sum(f.data, 7);
			owed_frames.push_back(f);
			made++;
			brake_roll++;
		end
		// steering frame closes every tick
		f = '0;
		f.id = ID_STEER;
		f.data[0] = STEER_BYTE0;
		f.data[1] = wheel_hi;
		f.data[2] = wheel_lo;
		f.data[3] = BYTE_20;
		f.data[7] = byte_sum(f.data, 4);
		f.last = 1'b1;
		owed_frames.push_back(f);
		made++;
		slot_q = (slot_q >= SLOT_LAST) ? 4'd0 : slot_q + 4'd1;
		return made;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	beat_t pending_beats[$];
	int unsigned total_beats;
	int unsigned beats_sent;
	int unsigned frames_due;   // updated with <= so the monitor sees a settled value
	int unsigned frames_seen;
	int unsigned mismatches = 0;

	function automatic beat_t tick_beat();
		beat_t b;
		b = '0;
		b.op = OP_TICK;
		{b.steer, b.throttle, b.brake} = 48'({$urandom, $urandom});
		b.gear = 8'($urandom);
		return b;
	endfunction

	function automatic beat_t cmd_beat(logic [15:0] st, logic [15:0] th, logic [15:0] br,
			logic [7:0] g);
		beat_t b;
		b = '0;
		b.op = OP_CMD;
		b.steer = st;
		b.throttle = th;
		b.brake = br;
		b.gear = g;
		return b;
	endfunction

	function automatic beat_t random_beat();
		beat_t b;
		b = tick_beat();
		if ($urandom_range(0, 9) < 4) begin
			b.op = OP_CMD;
			// bias steering onto the quantizer edges now and then
			if ($urandom_range(0, 5) == 0)
				b.steer = 16'(STEER_CENTER + ($urandom_range(0, 40) - 20) * STEER_STEP
					+ $urandom_range(0, 2) - 1);
			if ($urandom_range(0, 5) == 0)
				b.throttle = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			// about half the commands release the brake
			if ($urandom_range(0, 1))
				b.brake[15:8] = 8'($urandom_range(226, 255));
			case ($urandom_range(0, 2))
				0: b.gear = GEAR_CMD_FWD;
				1: b.gear = GEAR_CMD_REV;
				default: b.gear = 8'($urandom);
			endcase
		end
		return b;
	endfunction

	initial begin
		beat_t pause_mark;
		pause_mark = '0;
		pause_mark.pause = 1'b1;

		slot_q = 4'd0;
		gear_roll = 4'd0;
		brake_roll = 4'd0;
		wheel_hi = WHEEL_HI_RST;
		wheel_lo = WHEEL_LO_RST;
		speed_hi = 2'd0;
		speed_lo = 8'd0;
		shift = SHIFT_FWD;
		brake_level = 4'd0;

		// directed: reset values on slot 0, then one command before each of the next seven ticks
		pending_beats.push_back(tick_beat());
		// full left, throttle released, brake released, forward
		pending_beats.push_back(cmd_beat(16'h0000, 16'hFFFF, 16'hFFFF, GEAR_CMD_FWD));
		pending_beats.push_back(tick_beat());
		// full right, full throttle, full brake, reverse
		pending_beats.push_back(cmd_beat(16'hFFFF, 16'h0000, 16'h0000, GEAR_CMD_REV));
		pending_beats.push_back(tick_beat());
		// centre, speed step exactly one, weakest brake that still counts
		pending_beats.push_back(cmd_beat(16'h8000, 16'(THROTTLE_TOP - SPEED_STEP), 16'hE1FF,
			8'd1));
		pending_beats.push_back(tick_beat());
		// just left of centre, one short of a speed step, brake just released
		pending_beats.push_back(cmd_beat(16'h7FFF, 16'(THROTTLE_TOP - SPEED_STEP + 1),
			16'hE200, 8'hFF));
		pending_beats.push_back(tick_beat());
		// one full step left plus one, reverse without brake; slot 5 gear frame
		pending_beats.push_back(cmd_beat(16'(STEER_CENTER - STEER_STEP - 1), 16'h1234,
			16'hFFFF, GEAR_CMD_REV));
		pending_beats.push_back(tick_beat());
		// just under a step left rounds to zero
		pending_beats.push_back(cmd_beat(16'(STEER_CENTER - STEER_STEP + 1), 16'h5A5A,
			16'hE2FF, 8'h7F));
		pending_beats.push_back(tick_beat());
		// neutral, no brake, then wrap through slot 9 back to 0 and 1
		pending_beats.push_back(cmd_beat(16'(STEER_CENTER + STEER_STEP - 1), 16'hABCD,
			16'hFF00, 8'h80));
		repeat (5)
			pending_beats.push_back(tick_beat());
		pending_beats.push_back(pause_mark);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == PAUSE_AT)
				pending_beats.push_back(pause_mark);
			pending_beats.push_back(random_beat());
		end

		total_beats = 0;
		foreach (pending_beats[i])
			if (!pending_beats[i].pause)
				total_beats++;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// beats_sent and frames_due move together, so once every beat is in the
		// owed count is final
		while (beats_sent != total_beats)
			@(posedge clk);
		while (frames_seen != frames_due)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && frames_seen == frames_due)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: bursts of beats with random gaps, pause marks drain the block.
	// ------------------------------------------------------------------
	beat_t       offered;
	int          burst_left = 1;
	int          gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= OP_CMD;
			beats_sent <= 0;
			frames_due <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				frames_due <= frames_due + play_beat(offered);
				beats_sent <= beats_sent + 1;
			end
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_beats.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (pending_beats[0].pause) begin
				s_tvalid <= 1'b0;
				// a beat taken at this edge is not in frames_due yet; wait until s_tvalid is low
				if (!s_tvalid && frames_seen == frames_due)
					void'(pending_beats.pop_front());
			end else begin
				offered = pending_beats.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {offered.gear, offered.brake, offered.throttle, offered.steer};
				s_tuser <= offered.op;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 16);
					if ($urandom_range(0, 9) < 3)
						gap_left = 0;
					else if ($urandom_range(0, 9) < 7)
						gap_left = $urandom_range(1, 4);
					else
						gap_left = $urandom_range(5, 20);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each frame beat against the oldest owed frame and
	// drives tready from its own stall pattern plus one long hold.
	// ------------------------------------------------------------------
	frame_t      owed_head;
	ready_mode_t ready_mode = READY_ALWAYS;
	int          mode_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	function automatic void note_mismatch(string msg);
		if (mismatches < 10)
			$display("mismatch: %s", msg);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			frames_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (frames_seen >= frames_due) begin
					note_mismatch($sformatf("frame %0d id %h arrived with none owed",
						frames_seen, m_tuser));
				end else begin
					owed_head = owed_frames.pop_front();
					if (m_tuser !== owed_head.id)
						note_mismatch($sformatf("frame %0d id: expected %h got %h",
							frames_seen, owed_head.id, m_tuser));
					for (int i = 0; i < 8; i++)
						if (m_tdata[8*i +: 8] !== owed_head.data[i])
							note_mismatch($sformatf("frame %0d (id %h) data%0d: expected %h got %h",
								frames_seen, owed_head.id, i, owed_head.data[i], m_tdata[8*i +: 8]));
					if (m_tlast !== owed_head.last)
						note_mismatch($sformatf("frame %0d (id %h) last: expected %b got %b",
							frames_seen, owed_head.id, owed_head.last, m_tlast));
				end
				frames_seen <= frames_seen + 1;
			end

			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && frames_seen >= HOLD_AT_FRAME) begin
				// long back-pressure: the block fills and must stall its input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = ready_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(5, 40);
				end else begin
					mode_left--;
				end
				case (ready_mode)
					READY_ALWAYS: m_tready <= 1'b1;
					READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
					default:      m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long without a beat on either side means a hang.
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
